[rtl/core/i2c_oled_frame_writer_defines.svh]
// Assertion macros shared by the frame writer RTL.
`ifndef I2C_OLED_FRAME_WRITER_DEFINES_SVH
`define I2C_OLED_FRAME_WRITER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define OFW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define OFW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/i2c_ofw_pkg.sv]
package i2c_ofw_pkg;

  // Configuration register indexes
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SLAVE_ADDRESS = 1'b0;
  localparam cfg_idx_t CFG_ACK_TIMEOUT   = 1'b1;

  // Register reset values
  localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'h78;
  localparam logic [7:0] ACK_TIMEOUT_RESET   = 8'd250;

  // Control byte values
  localparam logic [7:0] CTRL_COMMAND = 8'h00;
  localparam logic [7:0] CTRL_DATA    = 8'h40;

  // Bus phases, one-hot
  typedef enum logic [11:0] {
    PH_IDLE     = 12'b0000_0000_0001,
    PH_START_A  = 12'b0000_0000_0010,
    PH_START_B  = 12'b0000_0000_0100,
    PH_BIT_LO1  = 12'b0000_0000_1000,
    PH_BIT_HI   = 12'b0000_0001_0000,
    PH_BIT_LO2  = 12'b0000_0010_0000,
    PH_ACK_SET  = 12'b0000_0100_0000,
    PH_ACK_WAIT = 12'b0000_1000_0000,
    PH_STOP_A   = 12'b0001_0000_0000,
    PH_STOP_B   = 12'b0010_0000_0000,
    PH_ABORT_A  = 12'b0100_0000_0000,
    PH_ABORT_B  = 12'b1000_0000_0000
  } phase_e;

  // One result word
  typedef struct packed {
    logic scl;
    logic sda_out;
    logic sda_drive;
    logic busy;
    logic done;
    logic err;
  } res_t;

  localparam res_t RES_IDLE = '{scl: 1'b1, sda_out: 1'b1, sda_drive: 1'b1,
                                busy: 1'b0, done: 1'b0, err: 1'b0};

endpackage

[rtl/core/i2c_oled_frame_writer.sv]
// Tick-driven I2C master that writes one frame (address, control byte, payload)
// per request. Every input word is one bus tick and yields exactly one result
// word with the SCL/SDA levels and frame status for that tick. The tick logic
// sits between the input port and a result register, so one word is taken
// every clock; a word is accepted whenever the result register is empty or
// being drained in the same cycle, so in_stall_o follows out_stall_i while a
// result is waiting. A word's result appears in the cycle after its acceptance.
`include "i2c_oled_frame_writer_defines.svh"

module i2c_oled_frame_writer #(
  parameter int EDGE_HOLD_TICKS = 4,
  parameter int HALF_BIT_TICKS  = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  i2c_ofw_pkg::cfg_idx_t cfg_idx_i,
  input  logic [7:0]            cfg_wdata_i,
  // input words
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  go_i,
  input  logic                  is_data_i,
  input  logic [7:0]            payload_i,
  input  logic                  sda_in_i,
  // result words
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  scl_o,
  output logic                  sda_out_o,
  output logic                  sda_drive_o,
  output logic                  busy_res_o,
  output logic                  done_res_o,
  output logic                  ack_error_o
);

  import i2c_ofw_pkg::*;

  localparam logic [3:0] EdgeN = 4'(EDGE_HOLD_TICKS);
  localparam logic [3:0] HalfN = 4'(HALF_BIT_TICKS);

  logic [7:0] slave_addr_q;
  logic [7:0] ack_timeout_q;

  phase_e     phase_q, phase_d, cur_phase;
  logic [2:0] tick_q, tick_d, cur_tick, tick_inc;
  logic [2:0] bit_q, bit_d;
  logic [1:0] byte_q, byte_d, byte_nxt;
  logic [7:0] wait_q, wait_d, wait_inc, limit;
  logic [7:0] shift_q, shift_d, cur_shift;
  logic [7:0] held_pl_q, held_pl_d;
  logic       held_dat_q, held_dat_d;
  logic       edge_last, half_last;
  res_t       res, res_q;
  logic       out_valid_q;
  logic       in_acc;

  assign in_acc     = in_valid_i & ~in_stall_o;
  assign in_stall_o = out_valid_q & out_stall_i;

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q  <= SLAVE_ADDRESS_RESET;
      ack_timeout_q <= ACK_TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SLAVE_ADDRESS: slave_addr_q  <= cfg_wdata_i;
        CFG_ACK_TIMEOUT:   ack_timeout_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Tick logic: start a frame from idle, then advance the bus phase
  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    bit_d      = bit_q;
    byte_d     = byte_q;
    wait_d     = wait_q;
    shift_d    = shift_q;
    held_pl_d  = held_pl_q;
    held_dat_d = held_dat_q;
    res        = RES_IDLE;
    cur_phase  = phase_q;
    cur_tick   = tick_q;
    cur_shift  = shift_q;

    case (phase_q)
      PH_START_A, PH_START_B, PH_BIT_LO1, PH_BIT_HI, PH_BIT_LO2, PH_ACK_SET,
      PH_ACK_WAIT, PH_STOP_A, PH_STOP_B, PH_ABORT_A, PH_ABORT_B: begin
      end
      default: begin
        cur_phase = PH_IDLE;
        if (go_i) begin
          held_dat_d = is_data_i;
          held_pl_d  = payload_i;
          byte_d     = 2'd0;
          bit_d      = 3'd0;
          wait_d     = 8'd0;
          shift_d    = slave_addr_q;
          cur_shift  = slave_addr_q;
          cur_tick   = 3'd0;
          cur_phase  = PH_START_A;
        end
      end
    endcase

    tick_inc  = cur_tick + 3'd1;
    edge_last = ({1'b0, cur_tick} + 4'd1) >= EdgeN;
    half_last = ({1'b0, cur_tick} + 4'd1) >= HalfN;
    wait_inc  = wait_q + 8'd1;
    limit     = (ack_timeout_q == 8'd0) ? 8'd1 : ack_timeout_q;
    byte_nxt  = byte_q + 2'd1;
    phase_d   = cur_phase;

    case (cur_phase)
      PH_START_A: begin
        res = '{scl: 1'b1, sda_out: 1'b1, sda_drive: 1'b1,
                busy: 1'b1, done: 1'b0, err: 1'b0};
        tick_d = edge_last ? 3'd0 : tick_inc;
        if (edge_last) phase_d = PH_START_B;
      end
      PH_START_B: begin
        res = '{scl: 1'b1, sda_out: 1'b0, sda_drive: 1'b1,
                busy: 1'b1, done: 1'b0, err: 1'b0};
        tick_d = edge_last ? 3'd0 : tick_inc;
        if (edge_last) phase_d = PH_BIT_LO1;
      end
      PH_BIT_LO1: begin
        res = '{scl: 1'b0, sda_out: cur_shift[7], sda_drive: 1'b1,
                busy: 1'b1, done: 1'b0, err: 1'b0};
        tick_d = half_last ? 3'd0 : tick_inc;
        if (half_last) phase_d = PH_BIT_HI;
      end
      PH_BIT_HI: begin
        res = '{scl: 1'b1, sda_out: cur_shift[7], sda_drive: 1'b1,
                busy: 1'b1, done: 1'b0, err: 1'b0};
        tick_d = half_last ? 3'd0 : tick_inc;
        if (half_last) phase_d = PH_BIT_LO2;
      end
      PH_BIT_LO2: begin
        res = '{scl: 1'b0, sda_out: cur_shift[7], sda_drive: 1'b1,
                busy: 1'b1, done: 1'b0, err: 1'b0};
        tick_d = half_last ? 3'd0 : tick_inc;
        if (half_last) begin
          shift_d = {cur_shift[6:0], 1'b0};
          if (bit_q == 3'd7) begin
            bit_d   = 3'd0;
            phase_d = PH_ACK_SET;
          end else begin
            bit_d   = bit_q + 3'd1;
            phase_d = PH_BIT_LO1;
          end
        end
      end
      PH_ACK_SET: begin
        // release SDA with SCL low
        res = '{scl: 1'b0, sda_out: 1'b1, sda_drive: 1'b0,
                busy: 1'b1, done: 1'b0, err: 1'b0};
        wait_d  = 8'd0;
        tick_d  = 3'd0;
        phase_d = PH_ACK_WAIT;
      end
      PH_ACK_WAIT: begin
        // hold SCL high until the slave pulls SDA low or the wait runs out
        res = '{scl: 1'b1, sda_out: 1'b1, sda_drive: 1'b0,
                busy: 1'b1, done: 1'b0, err: 1'b0};
        tick_d = 3'd0;
        if (!sda_in_i) begin
          wait_d = 8'd0;
          if (byte_q >= 2'd2) begin
            phase_d = PH_STOP_A;
          end else begin
            byte_d  = byte_nxt;
            shift_d = (byte_nxt == 2'd1) ? (held_dat_q ? CTRL_DATA : CTRL_COMMAND)
                                         : held_pl_q;
            bit_d   = 3'd0;
            phase_d = PH_BIT_LO1;
          end
        end else if (wait_inc >= limit) begin
          wait_d  = 8'd0;
          phase_d = PH_ABORT_A;
        end else begin
          wait_d = wait_inc;
        end
      end
      PH_STOP_A, PH_ABORT_A: begin
        res = '{scl: 1'b0, sda_out: 1'b0, sda_drive: 1'b1,
                busy: 1'b1, done: 1'b0, err: 1'b0};
        tick_d = edge_last ? 3'd0 : tick_inc;
        if (edge_last) phase_d = (cur_phase == PH_STOP_A) ? PH_STOP_B : PH_ABORT_B;
      end
      PH_STOP_B, PH_ABORT_B: begin
        res = '{scl: 1'b1, sda_out: 1'b1, sda_drive: 1'b1,
                busy: 1'b1, done: edge_last, err: edge_last & (cur_phase == PH_ABORT_B)};
        tick_d = edge_last ? 3'd0 : tick_inc;
        if (edge_last) begin
          phase_d = PH_IDLE;
          byte_d  = 2'd0;
          bit_d   = 3'd0;
        end
      end
      default: begin
        res = RES_IDLE;
      end
    endcase
  end

  // Advance control state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= 3'd0;
      bit_q   <= 3'd0;
      byte_q  <= 2'd0;
      wait_q  <= 8'd0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      wait_q  <= wait_d;
    end
  end

  // Hold frame bytes
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      shift_q    <= shift_d;
      held_pl_q  <= held_pl_d;
      held_dat_q <= held_dat_d;
    end
  end

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_o       = res_q.scl;
  assign sda_out_o   = res_q.sda_out;
  assign sda_drive_o = res_q.sda_drive;
  assign busy_res_o  = res_q.busy;
  assign done_res_o  = res_q.done;
  assign ack_error_o = res_q.err;

  // Checks
  `OFW_ASSERT_NOW(a_stall_when_full, out_valid_q && out_stall_i, in_stall_o, "accept while result held")
  `OFW_ASSERT_NEXT(a_accept_gives_result, in_acc, out_valid_o, "accepted word lost its result")
  `OFW_ASSERT_NEXT(a_done_returns_idle, in_acc && res.done, phase_q == PH_IDLE, "frame end missed idle")
  `OFW_ASSERT_NOW(a_idle_counters_clear, phase_q == PH_IDLE, byte_q == 2'd0 && bit_q == 3'd0, "counters left set in idle")
  `OFW_ASSERT_NOW(a_wait_in_range, 1'b1, wait_q != 8'hFF, "ack wait count overran")

endmodule
